// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 128;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_REVERSE    = 3'd5,
    CMD_SORT       = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_FRONT_W,
    ST_POP_BACK_W,
    ST_REV_RD,
    ST_REV_W1,
    ST_REV_W2,
    ST_SORT_KEY,
    ST_SORT_KEYW,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_REFRESH,
    ST_REFRESH_W,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/deq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// deq_cmd_if
// Command channel: one command word with its push value.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_cmd_if
  import deq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/deq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: status, popped word and queue view after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_rsp_if
  import deq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] popped_value;
  logic [COUNT_W-1:0]       fill_count;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic                     is_empty;

  modport source (output valid, output status, output popped_value, output fill_count,
                  output front_value, output back_value, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input fill_count,
                  input front_value, input back_value, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit words with reverse and sort commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command word (push front/back, pop front/back, clear,
//   reverse, sort) with its push value; rsp_o returns exactly one result word
//   per command: status, popped word, fill count, front and back words and
//   an empty flag. Both channels transfer on valid && ready.
// Steps per command (n = words stored), from acceptance to result loaded:
//   push, clear, errors and no-ops: straight to the result; pop: one read of
//   the new end word from the store, then the result.
//   reverse: one read and two writes per swapped pair, floor(n/2) pairs.
//   sort: insertion sort with one shift per cycle on the single write port,
//   then a read of the new front and back words.
// Commands are taken one at a time; a new command is accepted while the
// previous result still waits in the output register.
// Reset clears the head pointer, the fill count and the result valid; the
// store itself is not cleared. When rsp_o stalls, the finished result holds
// and the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  deq_cmd_if.sink   cmd_i,
  deq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr_a;
  logic [AW-1:0]     mem_raddr_b;
  logic [WORD_W-1:0] mem_rdata_a;
  logic [WORD_W-1:0] mem_rdata_b;

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .rsp_o         (rsp_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  deq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

`default_nettype wire

// ===== rtl/core/deq_mem.sv =====
// ----------------------------------------------------------------------------
// deq_mem
// Entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_mem
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WORD_W-1:0]          wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b_i,
  output      logic [WORD_W-1:0]          rdata_a_o,
  output      logic [WORD_W-1:0]          rdata_b_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read-before-write on a same-cycle address match
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: ring pointers, cached end words, reverse and sort walks,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  deq_cmd_if.sink                         cmd_i,
  deq_rsp_if.source                       rsp_o,
  output      logic                       mem_we_o,
  output      logic [$clog2(DEPTH)-1:0]   mem_waddr_o,
  output      logic [WORD_W-1:0]          mem_wdata_o,
  output      logic [$clog2(DEPTH)-1:0]   mem_raddr_a_o,
  output      logic [$clog2(DEPTH)-1:0]   mem_raddr_b_o,
  input  wire logic [WORD_W-1:0]          mem_rdata_a_i,
  input  wire logic [WORD_W-1:0]          mem_rdata_b_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // ring position of logical position pos (pos <= DEPTH)
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(pos);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [WORD_W-1:0]   front_q, front_d;
  logic [WORD_W-1:0]   back_q, back_d;
  logic [WORD_W-1:0]   key_q, key_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       j_q, j_d;
  status_e             status_q, status_d;
  logic [WORD_W-1:0]   popped_q, popped_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [WORD_W-1:0]   rsp_popped_q, rsp_popped_d;
  logic [COUNT_W-1:0]  rsp_fill_q, rsp_fill_d;
  logic [WORD_W-1:0]   rsp_front_q, rsp_front_d;
  logic [WORD_W-1:0]   rsp_back_q, rsp_back_d;
  logic                rsp_empty_q, rsp_empty_d;

  logic                full, empty;
  logic [AW-1:0]       head_dec;
  logic [CW-1:0]       i_inc;
  logic [CW-1:0]       back_pos;

  assign full     = (fill_q == CW'(DEPTH));
  assign empty    = (fill_q == '0);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign i_inc    = i_q + CW'(1);
  // new back after a pop at the back
  assign back_pos = (fill_q >= CW'(2)) ? fill_q - CW'(2) : '0;

  assign cmd_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.popped_value = rsp_popped_q;
  assign rsp_o.fill_count   = rsp_fill_q;
  assign rsp_o.front_value  = rsp_front_q;
  assign rsp_o.back_value   = rsp_back_q;
  assign rsp_o.is_empty     = rsp_empty_q;

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    fill_d        = fill_q;
    front_d       = front_q;
    back_d        = back_q;
    key_d         = key_q;
    i_d           = i_q;
    j_d           = j_q;
    status_d      = status_q;
    popped_d      = popped_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = head_q;
    mem_wdata_o   = cmd_i.push_value;
    mem_raddr_a_o = head_q;
    mem_raddr_b_o = slot(head_q, fill_q - CW'(1));

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_popped_d = rsp_popped_q;
    rsp_fill_d   = rsp_fill_q;
    rsp_front_d  = rsp_front_q;
    rsp_back_d   = rsp_back_q;
    rsp_empty_d  = rsp_empty_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          status_d = STATUS_OK;
          popped_d = '0;
          state_d  = ST_FIN;
          case (cmd_e'(cmd_i.command))
            CMD_PUSH_FRONT: begin
              if (full) begin
                status_d = STATUS_OVERFLOW;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = head_dec;
                head_d      = head_dec;
                fill_d      = fill_q + CW'(1);
                front_d     = cmd_i.push_value;
                if (empty) begin
                  back_d = cmd_i.push_value;
                end
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                status_d = STATUS_OVERFLOW;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = slot(head_q, fill_q);
                fill_d      = fill_q + CW'(1);
                back_d      = cmd_i.push_value;
                if (empty) begin
                  front_d = cmd_i.push_value;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                popped_d      = front_q;
                head_d        = slot(head_q, CW'(1));
                fill_d        = fill_q - CW'(1);
                mem_raddr_a_o = slot(head_q, CW'(1));
                state_d       = ST_POP_FRONT_W;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                popped_d      = back_q;
                fill_d        = fill_q - CW'(1);
                mem_raddr_b_o = slot(head_q, back_pos);
                state_d       = ST_POP_BACK_W;
              end
            end
            CMD_CLEAR: begin
              head_d = '0;
              fill_d = '0;
            end
            CMD_REVERSE: begin
              if (fill_q >= CW'(2)) begin
                i_d     = '0;
                j_d     = fill_q - CW'(1);
                state_d = ST_REV_RD;
              end
            end
            CMD_SORT: begin
              if (fill_q >= CW'(2)) begin
                i_d     = CW'(1);
                state_d = ST_SORT_KEY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_POP_FRONT_W: begin
        front_d = mem_rdata_a_i;
        state_d = ST_FIN;
      end

      ST_POP_BACK_W: begin
        back_d  = mem_rdata_b_i;
        state_d = ST_FIN;
      end

      // reverse: read a pair, then write it back crossed in ST_REV_W1 and ST_REV_W2
      ST_REV_RD: begin
        mem_raddr_a_o = slot(head_q, i_q);
        mem_raddr_b_o = slot(head_q, j_q);
        state_d       = ST_REV_W1;
      end

      ST_REV_W1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(head_q, i_q);
        mem_wdata_o = mem_rdata_b_i;
        key_d       = mem_rdata_a_i;
        state_d     = ST_REV_W2;
      end

      ST_REV_W2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(head_q, j_q);
        mem_wdata_o = key_q;
        i_d         = i_inc;
        j_d         = j_q - CW'(1);
        if (i_inc < j_q - CW'(1)) begin
          state_d = ST_REV_RD;
        end else begin
          front_d = back_q;
          back_d  = front_q;
          state_d = ST_FIN;
        end
      end

      // insertion sort, one shift per cycle
      ST_SORT_KEY: begin
        mem_raddr_a_o = slot(head_q, i_q);
        state_d       = ST_SORT_KEYW;
      end

      ST_SORT_KEYW: begin
        key_d         = mem_rdata_a_i;
        j_d           = i_q;
        mem_raddr_a_o = slot(head_q, i_q - CW'(1));
        state_d       = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot(head_q, j_q);
        if ($signed(mem_rdata_a_i) > $signed(key_q)) begin
          mem_wdata_o = mem_rdata_a_i;
          j_d         = j_q - CW'(1);
          if (j_q == CW'(1)) begin
            state_d = ST_SORT_PUT;
          end else begin
            mem_raddr_a_o = slot(head_q, j_q - CW'(2));
          end
        end else begin
          mem_wdata_o = key_q;
          i_d         = i_inc;
          state_d     = (i_inc < fill_q) ? ST_SORT_KEY : ST_REFRESH;
        end
      end

      ST_SORT_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = head_q;
        mem_wdata_o = key_q;
        i_d         = i_inc;
        state_d     = (i_inc < fill_q) ? ST_SORT_KEY : ST_REFRESH;
      end

      ST_REFRESH: begin
        mem_raddr_a_o = head_q;
        mem_raddr_b_o = slot(head_q, fill_q - CW'(1));
        state_d       = ST_REFRESH_W;
      end

      ST_REFRESH_W: begin
        front_d = mem_rdata_a_i;
        back_d  = mem_rdata_b_i;
        state_d = ST_FIN;
      end

      ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_popped_d = popped_q;
          rsp_fill_d   = COUNT_W'(fill_q);
          rsp_front_d  = empty ? '0 : front_q;
          rsp_back_d   = empty ? '0 : back_q;
          rsp_empty_d  = empty;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    back_q       <= back_d;
    key_q        <= key_d;
    i_q          <= i_d;
    j_q          <= j_d;
    status_q     <= status_d;
    popped_q     <= popped_d;
    rsp_status_q <= rsp_status_d;
    rsp_popped_q <= rsp_popped_d;
    rsp_fill_q   <= rsp_fill_d;
    rsp_front_q  <= rsp_front_d;
    rsp_back_q   <= rsp_back_d;
    rsp_empty_q  <= rsp_empty_d;
  end

endmodule

`default_nettype wire
